@@ rtl/pbd_pkg.sv @@
// pbd_pkg: shared types, widths and state encoding for the packet buffer drop block.
// No dependencies; used by packet_buffer_drop_sim.
`default_nettype none
package pbd_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RST = 7'd64;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_tick;
    logic [DUR_W-1:0]  duration;
  } in_t;

  typedef struct packed {
    logic              dropped;
    logic [TIME_W-1:0] begin_tick;
  } out_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } state_t;

endpackage
`default_nettype wire

@@ rtl/packet_buffer_drop_sim.sv @@
// packet_buffer_drop_sim: bounded-buffer packet drop model with a ring of finish times.
// Depends on pbd_pkg (types, widths, state enum).
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+------------------------------
//  input   | start, busy, in_data           | start && !busy
//  result  | out_valid, out_data            | out_valid (one cycle, no stall)
//  config  | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// An item is accepted in IDLE and then compared in CHECK: each compare of the
// ring head against the arrival in the shared comparator that finds it expired
// retires that entry, and the last compare makes the decision and the append.
// Retiring is bounded by the single-ported ring read, one entry per cycle.
// The result strobe is registered from the decision; a new item may be
// accepted while it is high. Reset (synchronous, rst_n low) empties the ring
// by clearing head, tail and occupancy; ring contents are not cleared.
`default_nettype none
module packet_buffer_drop_sim #(
  parameter int DEPTH = pbd_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire pbd_pkg::in_t            in_data,
  output logic                         out_valid,
  output pbd_pkg::out_t                out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [pbd_pkg::CAP_W-1:0]     cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;       // ring index width
  localparam int OW = $clog2(DEPTH + 1);                      // occupancy width
  localparam int CW = (OW > pbd_pkg::CAP_W) ? OW : pbd_pkg::CAP_W;
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CAP = CW'(DEPTH);
  localparam int TW = pbd_pkg::TIME_W;

  // ring of finish times, oldest at head
  logic [TW-1:0] ring_mem [DEPTH];
  logic [TW-1:0] rd_data_r;

  pbd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [TW-1:0] last_fin_r, last_fin_nxt;
  logic [pbd_pkg::CAP_W-1:0] cap_r;
  pbd_pkg::in_t  item_r;
  logic          out_valid_r, out_valid_nxt;
  pbd_pkg::out_t out_data_r, out_data_nxt;

  logic          accept;
  logic          retire;
  logic          full;
  logic          wr_en;
  logic [CW-1:0] cap_eff;
  logic [TW-1:0] start_t;
  logic [TW:0]   sum;
  logic [TW-1:0] fin;

  assign accept    = start && (state_r == pbd_pkg::ST_IDLE);
  assign busy      = (state_r != pbd_pkg::ST_IDLE);
  assign cfg_ready = (state_r == pbd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared compare / saturating add
  assign retire  = (occ_r != '0) && (rd_data_r <= item_r.arrival_tick);
  assign cap_eff = (CW'(cap_r) > DEPTH_CAP) ? DEPTH_CAP : CW'(cap_r);
  assign full    = (CW'(occ_r) >= cap_eff);
  assign start_t = (occ_r == '0) ? item_r.arrival_tick : last_fin_r;
  assign sum     = {1'b0, start_t} + (TW + 1)'(item_r.duration);
  assign fin     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign wr_en   = (state_r == pbd_pkg::ST_CHECK) && !retire && !full;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbd_pkg::ST_IDLE: begin
        if (accept) state_nxt = pbd_pkg::ST_CHECK;
      end
      pbd_pkg::ST_CHECK: begin
        if (!retire) state_nxt = pbd_pkg::ST_IDLE;
      end
      default: state_nxt = pbd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    last_fin_nxt  = last_fin_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      pbd_pkg::ST_IDLE: begin
      end
      pbd_pkg::ST_CHECK: begin
        if (retire) begin
          head_nxt = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
          occ_nxt  = occ_r - OW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_data_nxt.dropped    = 1'b1;
            out_data_nxt.begin_tick = item_r.arrival_tick;
          end else begin
            out_data_nxt.dropped    = 1'b0;
            out_data_nxt.begin_tick = start_t;
            tail_nxt     = (tail_r == LAST_IDX) ? '0 : tail_r + AW'(1);
            occ_nxt      = occ_r + OW'(1);
            last_fin_nxt = fin;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbd_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      last_fin_r  <= '0;
      cap_r       <= pbd_pkg::CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      last_fin_r  <= last_fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    out_data_r <= out_data_nxt;
  end

  // ring: one write, one registered read that follows the next head
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[tail_r] <= fin;
    rd_data_r <= ring_mem[head_nxt];
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(occ_r) <= DEPTH_CAP)
    else $error("occupancy above ring depth");

  a_out_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == pbd_pkg::ST_CHECK))
    else $error("result strobe without a decision");

  a_drop_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.dropped) |->
      (out_data_r.begin_tick == item_r.arrival_tick))
    else $error("dropped packet start differs from arrival");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accepting an item");

endmodule
`default_nettype wire

@@ verif/packet_buffer_drop_sim_tb.sv @@
// Self-checking testbench for packet_buffer_drop_sim: bounded ring of finish times,
// drop on full. Needs pbd_pkg and the packet_buffer_drop_sim RTL; nothing else.
`timescale 1ns / 1ps

module packet_buffer_drop_sim_tb;

  // Scoreboard: mirrors the ring of finish times and queues one expected
  // outcome per accepted packet.
  class drop_scoreboard;
    localparam int RING_DEPTH = pbd_pkg::DEPTH_DEF;
    localparam logic [pbd_pkg::TIME_W-1:0] TIME_MAX = '1;

    logic [pbd_pkg::TIME_W-1:0] finish_times[RING_DEPTH];
    int unsigned                oldest;
    int unsigned                held;
    logic [pbd_pkg::TIME_W-1:0] newest_finish;
    logic [pbd_pkg::CAP_W-1:0]  capacity;
    logic [pbd_pkg::TIME_W-1:0] prev_arrival;
    pbd_pkg::out_t              expected_q[$];

    int unsigned n_packets, n_dropped, n_retired, n_saturated, n_out_of_order;
    int unsigned n_checked, n_failures;

    function new();
      oldest        = 0;
      held          = 0;
      newest_finish = '0;
      capacity      = pbd_pkg::CAP_RST;
      prev_arrival  = '0;
    endfunction

    function void set_capacity(logic [pbd_pkg::CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Work out the outcome of one accepted packet and update the ring.
    function void accept_packet(pbd_pkg::in_t pkt);
      int unsigned                limit;
      logic [pbd_pkg::TIME_W:0]   sum;
      logic [pbd_pkg::TIME_W-1:0] begin_at;
      logic [pbd_pkg::TIME_W-1:0] done_at;
      pbd_pkg::out_t              outcome;
      limit = (capacity > RING_DEPTH) ? RING_DEPTH : capacity;
      if (n_packets > 0 && pkt.arrival_tick < prev_arrival) n_out_of_order++;
      prev_arrival = pkt.arrival_tick;
      n_packets++;
      // every expired entry goes, head first (entries stay sorted)
      while (held > 0 && finish_times[oldest] <= pkt.arrival_tick) begin
        oldest = (oldest + 1) % RING_DEPTH;
        held--;
        n_retired++;
      end
      if (held >= limit) begin
        outcome.dropped    = 1'b1;
        outcome.begin_tick = pkt.arrival_tick;
        n_dropped++;
      end else begin
        begin_at = (held == 0) ? pkt.arrival_tick : newest_finish;
        sum      = {1'b0, begin_at} + pkt.duration;
        done_at  = sum[pbd_pkg::TIME_W] ? TIME_MAX : sum[pbd_pkg::TIME_W-1:0];
        if (sum[pbd_pkg::TIME_W]) n_saturated++;
        finish_times[(oldest + held) % RING_DEPTH] = done_at;
        held++;
        newest_finish      = done_at;
        outcome.dropped    = 1'b0;
        outcome.begin_tick = begin_at;
      end
      expected_q = {expected_q, outcome};
    endfunction

    function void note_failure(string what);
      n_failures++;
      if (n_failures <= 10) $display("MISMATCH %s", what);
    endfunction

    function void check_outcome(pbd_pkg::out_t got);
      pbd_pkg::out_t want;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("result with nothing expected: dropped=%0b start=%0h",
                               got.dropped, got.begin_tick));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.dropped !== want.dropped)
        note_failure($sformatf("result %0d dropped: expected %0b, got %0b",
                               n_checked, want.dropped, got.dropped));
      if (got.begin_tick !== want.begin_tick)
        note_failure($sformatf("result %0d start tick: expected %0h, got %0h",
                               n_checked, want.begin_tick, got.begin_tick));
    endfunction
  endclass

  // Clock, reset, DUT pins. Inputs are known from time zero.
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  pbd_pkg::in_t              in_data   = '0;
  logic                      cfg_valid = 1'b0;
  logic [pbd_pkg::CAP_W-1:0] cfg_data  = '0;
  logic                      busy;
  logic                      out_valid;
  pbd_pkg::out_t             out_data;
  logic                      cfg_ready;

  drop_scoreboard pkt_board = new();
  int unsigned    n_settings = 0;

  always #5 clk = ~clk;

  packet_buffer_drop_sim u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Result side: the strobe lasts one cycle and cannot be stalled, so every
  // edge with out_valid high is a transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid) pkt_board.check_outcome(out_data);
  end

  // One packet transfer. start stays high between back-to-back packets
  // (gap 0) so it never gets lowered and raised in the same time step.
  task automatic send_packet(input logic [pbd_pkg::TIME_W-1:0] arrival,
                             input logic [pbd_pkg::DUR_W-1:0] dur, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start                <= 1'b1;
    in_data.arrival_tick <= arrival;
    in_data.duration     <= dur;
    @(posedge clk);
    while (busy) @(posedge clk);
    pkt_board.accept_packet('{arrival_tick: arrival, duration: dur});
  endtask

  // Sender holds off until every outstanding result is back; every packet
  // makes a result, so nothing is left in flight after that.
  task automatic wait_idle();
    start <= 1'b0;
    while (pkt_board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [pbd_pkg::CAP_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pkt_board.set_capacity(value);
    n_settings++;
  endtask

  function automatic int draw_gap();
    return $urandom_range(0, 10);
  endfunction

  // Stimulus
  initial begin
    int                         cap_plan[9] = '{64, 4, 1, 0, 127, 16, 65, 0, 0};
    logic [pbd_pkg::TIME_W-1:0] now_tick;
    logic [pbd_pkg::TIME_W-1:0] arrival;
    logic [pbd_pkg::DUR_W-1:0]  dur;
    logic [pbd_pkg::CAP_W-1:0]  cap;
    bit                         no_gaps;
    int                         roll;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset capacity: zero duration, full-scale duration, late arrival
    send_packet(32'd0, 16'd0, draw_gap());
    send_packet(32'd0, 16'hFFFF, draw_gap());
    send_packet(32'd10, 16'd7, draw_gap());
    send_packet(32'd5, 16'd3, draw_gap());      // arrival goes backwards

    // capacity one: full ring drops, retire on equal finish time
    write_capacity(7'd1);
    send_packet(32'd100, 16'd50, draw_gap());
    send_packet(32'd70000, 16'd50, draw_gap());
    send_packet(32'd70010, 16'd5, draw_gap());
    send_packet(32'd70050, 16'd0, draw_gap());

    // capacity above ring depth saturates; finish times saturate near max
    write_capacity(7'd127);
    send_packet(32'd80000, 16'hFFFF, draw_gap());
    send_packet(32'd80000, 16'hFFFF, draw_gap());
    send_packet(32'd80000, 16'hFFFF, draw_gap());
    send_packet(32'd79000, 16'd0, draw_gap());
    send_packet(32'hFFFF_FFF0, 16'hFFFF, draw_gap());
    send_packet(32'hFFFF_FFFF, 16'hFFFF, draw_gap());
    send_packet(32'd0, 16'd0, draw_gap());

    // capacity zero: all dropped; the max arrival still retires the ring
    write_capacity(7'd0);
    send_packet(32'hFFFF_FFFF, 16'd5, draw_gap());
    send_packet(32'd0, 16'd1, draw_gap());
    send_packet(32'd0, 16'd0, draw_gap());

    // --- random part: ~110 packets per capacity setting ---
    // Arrivals mostly creep forward in small steps while durations run longer,
    // so the ring fills and drains; a few jump ahead or step backwards.
    now_tick = '0;
    no_gaps  = 1'b0;
    foreach (cap_plan[p]) begin
      cap = (p >= 7) ? pbd_pkg::CAP_W'($urandom_range(0, 127))
                     : pbd_pkg::CAP_W'(cap_plan[p]);
      write_capacity(cap);
      repeat (110) begin
        if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
        roll = $urandom_range(0, 99);
        if (roll < 85) dur = pbd_pkg::DUR_W'($urandom_range(0, 150));
        else if (roll < 95) dur = pbd_pkg::DUR_W'($urandom_range(0, 65535));
        else dur = '0;
        roll = $urandom_range(0, 99);
        if (roll < 2 && now_tick < 32'hFFF0_0000) begin
          now_tick = $urandom_range(now_tick, 32'hFFF0_0000);
          arrival  = now_tick;
        end else if (roll < 6) begin
          arrival = $urandom_range(0, now_tick);   // stray late packet
        end else begin
          now_tick = now_tick + $urandom_range(0, 60);
          arrival  = now_tick;
        end
        send_packet(arrival, dur, no_gaps ? 0 : draw_gap());
      end
    end

    // --- wrap-up ---
    wait_idle();
    repeat (80) @(posedge clk);
    pkt_board.n_failures += pkt_board.pending();
    $display("Covered %0d packets over %0d capacity writes: %0d dropped, %0d retired,",
             pkt_board.n_packets, n_settings, pkt_board.n_dropped, pkt_board.n_retired);
    $display("  %0d saturated finish times, %0d out-of-order arrivals, %0d errors",
             pkt_board.n_saturated, pkt_board.n_out_of_order, pkt_board.n_failures);
    if (pkt_board.n_failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: 20 ms, longer than the worst legal run (every packet retiring a
  // full ring, longest sender gaps).
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pbd_pkg.sv
rtl/packet_buffer_drop_sim.sv
verif/packet_buffer_drop_sim_tb.sv
